// ===== sv/envelope_smoother_decay_assert.svh =====
// Assertion macros shared by the envelope smoother modules.
`ifndef ENVELOPE_SMOOTHER_DECAY_ASSERT_SVH
`define ENVELOPE_SMOOTHER_DECAY_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define ESD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/esd_pkg.sv =====
// Shared types and constants for the envelope smoother.
package esd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int WLEN_W         = 9;
    localparam int DECAY_W        = 16;
    localparam int COEFF_W        = 32;
    localparam int MAX_WINDOW_DEF = 256;

    localparam logic [SAMPLE_W-1:0] DC_OFFSET_RST = 16'd0;
    localparam logic [WLEN_W-1:0]   WLEN_RST      = 9'd48;
    localparam logic [DECAY_W-1:0]  DECAY_RST     = 16'd62156;
    localparam logic [COEFF_W-1:0]  COEFF_RST     = 32'd466;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DC_OFFSET      = 2'd0,
        CFG_WINDOW_LENGTH  = 2'd1,
        CFG_DECAY_FACTOR   = 2'd2,
        CFG_PARABOLA_COEFF = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic step_window;  // add new value, write and read window store
        logic step_sub;     // drop the oldest value from the sum
        logic div_start;    // launch the mean division
        logic step_cmp;     // rise test, state update, first products
        logic step_mul1;
        logic step_mul2;
        logic step_mul3;
        logic load_out;     // move results into the output register
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// ===== sv/esd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module esd_div #(
    parameter int DVS_W = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [esd_pkg::SUM_W-1:0]   i_dividend,
    input  logic [DVS_W-1:0]            i_divisor,
    output logic [esd_pkg::SUM_W-1:0]   o_quotient,
    output logic                        o_done
);

    localparam int CNT_W = $clog2(esd_pkg::SUM_W);

    logic [esd_pkg::SUM_W-1:0] r_quo;
    logic [DVS_W-1:0]          r_rem;
    logic [DVS_W-1:0]          r_dvs;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [DVS_W:0] trial;
    logic           ge;
    logic [DVS_W:0] diff;

    always_comb begin
        trial = {r_rem, r_quo[esd_pkg::SUM_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(esd_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[esd_pkg::SUM_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== sv/esd_dp.sv =====
// Datapath: configuration, window store, running sum, divider and decay products.
`include "envelope_smoother_decay_assert.svh"

module esd_dp #(
    parameter int MAX_WINDOW = esd_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [esd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic signed [esd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_start_of_record,
    input  esd_pkg::t_cmd                      i_cmd,
    output esd_pkg::t_status                   o_status,
    output logic [esd_pkg::SAMPLE_W-1:0]       o_rectified,
    output logic [esd_pkg::SAMPLE_W-1:0]       o_smoothed,
    output logic [esd_pkg::SAMPLE_W-1:0]       o_rise_exp,
    output logic [esd_pkg::SAMPLE_W-1:0]       o_rise_parabola
);

    localparam int SW     = esd_pkg::SAMPLE_W;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W  = (FILL_W > esd_pkg::WLEN_W) ? FILL_W : esd_pkg::WLEN_W;
    localparam int IDX_W  = FILL_W + 1;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // configuration
    logic signed [SW-1:0]            r_dc_offset;
    logic [esd_pkg::WLEN_W-1:0]      r_wlen;
    logic [esd_pkg::DECAY_W-1:0]     r_decay;
    logic [esd_pkg::COEFF_W-1:0]     r_coeff;

    // record state
    logic [esd_pkg::SUM_W-1:0] r_sum;
    logic [FILL_W-1:0]         r_fill;
    logic [PTR_W-1:0]          r_wp;
    logic [SW-1:0]             r_prev;
    logic [SW-1:0]             r_exp;
    logic [SW-1:0]             r_peak;
    logic [SW-1:0]             r_ssr;

    // per-item working registers
    logic [SW-1:0]             r_win_mem [MAX_WINDOW];
    logic [SW-1:0]             r_rect;
    logic [SW-1:0]             r_rd;
    logic                      r_sub_en;
    logic [FILL_W-1:0]         r_div;
    logic                      r_rise;
    logic [31:0]               r_expprod;
    logic [31:0]               r_nsq;
    logic [63:0]               r_prod;
    logic [32:0]               r_w;
    logic [48:0]               r_parprod;

    logic [SW-1:0]             r_o_rect;
    logic [SW-1:0]             r_o_smooth;
    logic [SW-1:0]             r_o_exp;
    logic [SW-1:0]             r_o_par;

    logic signed [SW:0]        diff;
    logic [SW:0]               mag;
    logic [SW-1:0]             rect;
    logic [CMP_W-1:0]          wl_ext;
    logic [CMP_W-1:0]          len_c;
    logic [FILL_W-1:0]         len;
    logic [IDX_W-1:0]          idx_t;
    logic [PTR_W-1:0]          rd_idx;
    logic [FILL_W-1:0]         n_fill;
    logic [PTR_W-1:0]          n_wp;
    logic [esd_pkg::SUM_W-1:0] quo;
    logic                      div_done;
    logic [SW-1:0]             mean;
    logic [SW-1:0]             n_ssr;

    esd_div #(
        .DVS_W (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_div),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    always_comb begin
        diff = {i_sample[SW-1], i_sample} - {r_dc_offset[SW-1], r_dc_offset};
        mag  = diff[SW] ? (~diff + 1'b1) : diff;
        rect = mag[SW-1:0];

        // clamp window length into 1..MAX_WINDOW
        wl_ext = CMP_W'(r_wlen);
        if (wl_ext == '0) begin
            len_c = CMP_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            len_c = CMP_W'(MAX_WINDOW);
        end else begin
            len_c = wl_ext;
        end
        len = FILL_W'(len_c);

        idx_t = IDX_W'(r_wp) + IDX_W'(MAX_WINDOW) - IDX_W'(len);
        if (idx_t >= IDX_W'(MAX_WINDOW)) begin
            idx_t = idx_t - IDX_W'(MAX_WINDOW);
        end
        rd_idx = PTR_W'(idx_t);

        n_fill = (r_fill < FILL_W'(MAX_WINDOW)) ? r_fill + 1'b1 : r_fill;
        n_wp   = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;

        mean  = (|quo[esd_pkg::SUM_W-1:SW]) ? '1 : quo[SW-1:0];
        n_ssr = (r_ssr == '1) ? r_ssr : r_ssr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset <= esd_pkg::DC_OFFSET_RST;
            r_wlen      <= esd_pkg::WLEN_RST;
            r_decay     <= esd_pkg::DECAY_RST;
            r_coeff     <= esd_pkg::COEFF_RST;
        end else if (i_cfg_we) begin
            case (esd_pkg::t_cfg_idx'(i_cfg_idx))
                esd_pkg::CFG_DC_OFFSET:      r_dc_offset <= i_cfg_wdata[SW-1:0];
                esd_pkg::CFG_WINDOW_LENGTH:  r_wlen <= i_cfg_wdata[esd_pkg::WLEN_W-1:0];
                esd_pkg::CFG_DECAY_FACTOR:   r_decay <= i_cfg_wdata[esd_pkg::DECAY_W-1:0];
                esd_pkg::CFG_PARABOLA_COEFF: r_coeff <= i_cfg_wdata[esd_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
            r_prev <= '0;
            r_exp  <= '0;
            r_peak <= '0;
            r_ssr  <= '0;
        end else if (i_cmd.accept) begin
            if (i_start_of_record) begin
                r_sum  <= '0;
                r_fill <= '0;
                r_wp   <= '0;
                r_prev <= '0;
                r_exp  <= '0;
                r_peak <= '0;
                r_ssr  <= '0;
            end
        end else if (i_cmd.step_window) begin
            r_sum  <= r_sum + esd_pkg::SUM_W'(r_rect);
            r_fill <= n_fill;
            r_wp   <= n_wp;
        end else if (i_cmd.step_sub) begin
            r_sum <= r_sum - (r_sub_en ? esd_pkg::SUM_W'(r_rd) : '0);
        end else if (i_cmd.step_cmp) begin
            r_prev <= mean;
            if (mean >= r_prev) begin
                r_exp  <= mean;
                r_peak <= mean;
                r_ssr  <= '0;
            end else begin
                r_ssr <= n_ssr;
            end
        end else if (i_cmd.step_mul1) begin
            if (!r_rise) begin
                r_exp <= r_expprod[31:16];
            end
        end
    end

    // window store: read the oldest entry before overwriting the slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.step_window) begin
            r_win_mem[r_wp] <= r_rect;
            r_rd            <= r_win_mem[rd_idx];
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rect <= rect;
        end
        if (i_cmd.step_window) begin
            r_sub_en <= (r_fill >= len);
            r_div    <= (n_fill < len) ? n_fill : len;
        end
        if (i_cmd.step_cmp) begin
            r_rise    <= (mean >= r_prev);
            r_expprod <= 32'(r_exp) * 32'(r_decay);
            r_nsq     <= 32'(n_ssr) * 32'(n_ssr);
        end
        if (i_cmd.step_mul1) begin
            r_prod <= 64'(r_nsq) * 64'(r_coeff);
        end
        if (i_cmd.step_mul2) begin
            r_w <= (|r_prod[63:32]) ? '0 : ONE_Q32 - {1'b0, r_prod[31:0]};
        end
        if (i_cmd.step_mul3) begin
            r_parprod <= 49'(r_peak) * 49'(r_w);
        end
        if (i_cmd.load_out) begin
            r_o_rect   <= r_rect;
            r_o_smooth <= r_prev;
            r_o_exp    <= r_exp;
            r_o_par    <= r_rise ? r_peak : r_parprod[47:32];
        end
    end

    assign o_status.div_done = div_done;
    assign o_rectified       = r_o_rect;
    assign o_smoothed        = r_o_smooth;
    assign o_rise_exp        = r_o_exp;
    assign o_rise_parabola   = r_o_par;

    `ESD_ASSERT_IMPL(a_div_nonzero, i_cmd.div_start, r_div != '0, "divisor is zero at launch")
    `ESD_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= FILL_W'(MAX_WINDOW), "fill count past window depth")

endmodule

// ===== sv/esd_ctrl.sv =====
// Controller: sequences one item through the datapath and owns the output valid.
`include "envelope_smoother_decay_assert.svh"

module esd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  esd_pkg::t_status i_status,
    output esd_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WINDOW,
        S_SUB,
        S_DIVGO,
        S_DIVWAIT,
        S_CMP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   load;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WINDOW;
                end
            end
            S_WINDOW: begin
                o_cmd.step_window = 1'b1;
                n_state           = S_SUB;
            end
            S_SUB: begin
                o_cmd.step_sub = 1'b1;
                n_state        = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.step_cmp = 1'b1;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.step_mul1 = 1'b1;
                n_state         = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.step_mul2 = 1'b1;
                n_state         = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.step_mul3 = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (load) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ESD_ASSERT_IMPL(a_done_in_wait, i_status.div_done, r_state == S_DIVWAIT, "divider done outside wait")
    `ESD_ASSERT_NEXT(a_busy_after_xfer, i_in_valid && o_in_ready, !o_in_ready, "ready right after transfer")
    `ESD_ASSERT_IMPL(a_valid_from_out, $rose(r_out_valid), $past(r_state) == S_OUT, "result without load")

endmodule

// ===== sv/envelope_smoother_decay.sv =====
// One item in flight at a time: a new input is taken only after the last result is loaded,
// and the mean of each item is formed by the 32-step restoring divider.
// A finished result waits in the output register while the next item is taken and worked.
// Reset (synchronous, active low) clears the record state and loads register defaults;
// the window store is not cleared, only entries written in the current record are read.
module envelope_smoother_decay #(
    parameter int MAX_WINDOW = esd_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [esd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [esd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_start_of_record,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [esd_pkg::SAMPLE_W-1:0]        o_rectified,
    output logic [esd_pkg::SAMPLE_W-1:0]        o_smoothed,
    output logic [esd_pkg::SAMPLE_W-1:0]        o_rise_exp,
    output logic [esd_pkg::SAMPLE_W-1:0]        o_rise_parabola
);

    esd_pkg::t_cmd    cmd;
    esd_pkg::t_status status;

    esd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    esd_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_sample          (i_sample),
        .i_start_of_record (i_start_of_record),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_rectified       (o_rectified),
        .o_smoothed        (o_smoothed),
        .o_rise_exp        (o_rise_exp),
        .o_rise_parabola   (o_rise_parabola)
    );

endmodule

// ===== sim/envelope_smoother_decay_tb.sv =====
// Self-checking testbench for the envelope smoother: directed table, then random phases.
module envelope_smoother_decay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int     NUM_PHASES   = 12;
    localparam int     RANDOM_ITEMS = 1650;
    localparam int     MAX_REPORTS  = 10;
    localparam int     WINDOW_DEPTH = MAX_WINDOW_DEF;
    localparam int     TAIL_CYCLES  = 60;
    localparam longint TIMEOUT_NS   = 10_000_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rectified;
        logic [SAMPLE_W-1:0] smoothed;
        logic [SAMPLE_W-1:0] rise_exp;
        logic [SAMPLE_W-1:0] rise_parabola;
    } env_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        t_cfg_idx               reg_idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   sor;
        logic                   fixed;
        env_result_t            want;
    } dir_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_DATA_W-1:0]      i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_start_of_record;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [SAMPLE_W-1:0]        o_rectified;
    logic [SAMPLE_W-1:0]        o_smoothed;
    logic [SAMPLE_W-1:0]        o_rise_exp;
    logic [SAMPLE_W-1:0]        o_rise_parabola;

    envelope_smoother_decay uut (.*);

    // Register shadows
    logic signed [SAMPLE_W-1:0] offset_reg;
    logic [WLEN_W-1:0]          win_len_reg;
    logic [DECAY_W-1:0]         decay_reg;
    logic [COEFF_W-1:0]         coeff_reg;

    // Envelope state
    logic [SAMPLE_W-1:0]        win_mem [WINDOW_DEPTH];
    logic [31:0]                win_sum;
    int unsigned                fill_cnt;
    logic [7:0]                 wr_ptr;
    logic [SAMPLE_W-1:0]        last_mean;
    logic [SAMPLE_W-1:0]        exp_env;
    logic [SAMPLE_W-1:0]        peak_env;
    logic [15:0]                fall_cnt;

    env_result_t                pending_env_q [$];
    dir_row_t                   dir_rows [$];
    int                         mismatch_cnt = 0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;

    function automatic void clear_envelope_record();
        win_sum   = '0;
        fill_cnt  = 0;
        wr_ptr    = '0;
        last_mean = '0;
        exp_env   = '0;
        peak_env  = '0;
        fall_cnt  = '0;
    endfunction

    function automatic env_result_t envelope_predict(input logic [SAMPLE_W-1:0] smp,
                                                     input logic sor);
        env_result_t r;
        int          diff;
        int unsigned len;
        int unsigned divisor;
        logic [31:0] rect;
        logic [31:0] mean;
        logic [31:0] decay_prod;
        logic [63:0] n;
        logic [63:0] par_w;
        logic [63:0] par_prod;
        if (sor)
            clear_envelope_record();
        diff = int'($signed(smp)) - int'(offset_reg);
        rect = (diff < 0) ? -diff : diff;

        len = win_len_reg;
        if (len == 0)
            len = 1;
        if (len > WINDOW_DEPTH)
            len = WINDOW_DEPTH;

        // drop the value that leaves the window before overwriting its slot
        win_sum += rect;
        if (fill_cnt >= len)
            win_sum -= {16'b0, win_mem[wr_ptr - 8'(len)]};
        win_mem[wr_ptr] = rect[15:0];
        wr_ptr++;
        if (fill_cnt < WINDOW_DEPTH)
            fill_cnt++;

        divisor = (fill_cnt < len) ? fill_cnt : len;
        mean = win_sum / divisor;
        if (mean > 32'hFFFF)
            mean = 32'hFFFF;

        r.rectified = rect[15:0];
        r.smoothed  = mean[15:0];
        if (mean[15:0] >= last_mean) begin
            exp_env         = mean[15:0];
            peak_env        = mean[15:0];
            fall_cnt        = '0;
            r.rise_exp      = mean[15:0];
            r.rise_parabola = mean[15:0];
        end else begin
            if (fall_cnt != 16'hFFFF)
                fall_cnt++;
            decay_prod = {16'b0, exp_env} * {16'b0, decay_reg};
            exp_env    = decay_prod[31:16];
            n          = {48'b0, fall_cnt};
            par_prod   = n * n * {32'b0, coeff_reg};
            par_w      = (par_prod >= 64'h1_0000_0000) ? 64'd0 : 64'h1_0000_0000 - par_prod;
            par_prod   = {48'b0, peak_env} * par_w;
            r.rise_exp      = exp_env;
            r.rise_parabola = par_prod[47:32];
        end
        last_mean = mean[15:0];
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] make_sample(input int shape, input logic in_burst);
        logic [SAMPLE_W-1:0] smp;
        case (shape)
            0: smp = 16'($urandom);
            // burst, then a quiet tail near the offset so the envelopes decay
            1: smp = in_burst ? 16'($urandom)
                              : offset_reg + 16'($urandom_range(0, 32)) - 16'd16;
            2: smp = offset_reg + 16'($urandom_range(0, 256)) - 16'd128;
            default: begin
                case ($urandom_range(2))
                    0:       smp = 16'h8000;
                    1:       smp = 16'h7FFF;
                    default: smp = offset_reg;
                endcase
            end
        endcase
        return smp;
    endfunction

    function automatic void add_sample(input logic [SAMPLE_W-1:0] smp, input logic sor);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.value = {16'b0, smp};
        row.sor   = sor;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic [SAMPLE_W-1:0] smp, input logic sor,
                                      input env_result_t want);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.value = {16'b0, smp};
        row.sor   = sor;
        row.fixed = 1'b1;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = data;
        dir_rows.push_back(row);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DC_OFFSET:      offset_reg  = data[SAMPLE_W-1:0];
            CFG_WINDOW_LENGTH:  win_len_reg = data[WLEN_W-1:0];
            CFG_DECAY_FACTOR:   decay_reg   = data[DECAY_W-1:0];
            CFG_PARABOLA_COEFF: coeff_reg   = data[COEFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic sor,
                               input logic fixed, input env_result_t want);
        env_result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_sample          <= smp;
        i_start_of_record <= sor;
        do @(posedge i_clk); while (!o_in_ready);
        pred = envelope_predict(smp, sor);
        pending_env_q.push_back(fixed ? want : pred);
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_env_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("envelope_smoother_decay_tb: errors");
        $finish;
    end

    // Result side: random back-pressure and in-order compare.
    initial begin
        env_result_t got;
        env_result_t want;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = {o_rectified, o_smoothed, o_rise_exp, o_rise_parabola};
                if (pending_env_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected result: rect=%0d smooth=%0d exp=%0d par=%0d",
                                 got.rectified, got.smoothed, got.rise_exp, got.rise_parabola);
                end else begin
                    want = pending_env_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("mismatch at %0t expected/actual: rect %0d/%0d",
                                     $realtime, want.rectified, got.rectified);
                            $display("    smooth %0d/%0d exp %0d/%0d par %0d/%0d",
                                     want.smoothed, got.smoothed,
                                     want.rise_exp, got.rise_exp,
                                     want.rise_parabola, got.rise_parabola);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        dir_row_t            row;
        logic [SAMPLE_W-1:0] off;
        logic [WLEN_W-1:0]   wlen;
        logic [DECAY_W-1:0]  dk;
        logic [COEFF_W-1:0]  cf;
        logic [SAMPLE_W-1:0] smp;
        logic                sor;
        logic                keep_record;
        int                  phase_items;
        int                  rec_len;
        int                  shape;
        int                  burst;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_DC_OFFSET;
        i_cfg_wdata       <= '0;
        i_in_valid        <= 1'b0;
        i_sample          <= '0;
        i_start_of_record <= 1'b0;

        offset_reg  = DC_OFFSET_RST;
        win_len_reg = WLEN_RST;
        decay_reg   = DECAY_RST;
        coeff_reg   = COEFF_RST;
        clear_envelope_record();

        // first sample of a record is its own mean, so every view equals the rectified value
        add_known(16'd0,    1'b1, {4{16'd0}});
        add_known(16'h7FFF, 1'b1, {4{16'd32767}});
        add_known(16'h8000, 1'b1, {4{16'd32768}});
        add_known(16'h8000, 1'b0, {4{16'd32768}});   // equal mean counts as a rise
        add_sample(16'd0, 1'b0);
        add_sample(16'd0, 1'b0);
        add_sample(16'd0, 1'b0);
        add_known(16'd100,  1'b1, {4{16'd100}});
        add_write(CFG_DC_OFFSET, 32'h0000_8000);
        add_known(16'h7FFF, 1'b1, {4{16'hFFFF}});
        add_write(CFG_DC_OFFSET, 32'h0000_7FFF);
        add_known(16'h8000, 1'b1, {4{16'hFFFF}});
        add_sample(16'h7FFF, 1'b0);
        add_write(CFG_DC_OFFSET, 32'd0);
        add_write(CFG_DECAY_FACTOR, 32'd0);
        add_write(CFG_PARABOLA_COEFF, 32'd0);
        add_known(16'd1000, 1'b1, {4{16'd1000}});
        // zero decay drops at once, zero coefficient holds the peak
        add_known(16'd0, 1'b0, {16'd0, 16'd500, 16'd0, 16'd1000});
        add_known(16'd0, 1'b0, {16'd0, 16'd333, 16'd0, 16'd1000});
        add_write(CFG_DECAY_FACTOR, 32'h0000_FFFF);
        add_write(CFG_PARABOLA_COEFF, 32'hFFFF_FFFF);
        add_write(CFG_WINDOW_LENGTH, 32'd1);
        add_known(16'd5000, 1'b1, {4{16'd5000}});
        add_sample(16'd4000, 1'b0);
        add_known(16'd4000, 1'b0, {4{16'd4000}});
        add_write(CFG_WINDOW_LENGTH, 32'd0);
        add_known(16'd7, 1'b1, {4{16'd7}});
        add_sample(16'hFFFD, 1'b0);
        add_write(CFG_WINDOW_LENGTH, 32'd511);
        add_sample(16'd10, 1'b1);
        add_sample(16'd20, 1'b0);
        add_sample(16'd30, 1'b0);
        add_sample(16'hFFFB, 1'b0);

        send_idle_pct = 33;
        recv_idle_pct = 72;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_sample(row.value[SAMPLE_W-1:0], row.sor, row.fixed, row.want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 33 : ((ph < 8) ? 72 : 0);
            recv_idle_pct = (ph < 4) ? 72 : ((ph < 8) ? 33 : 0);
            wait_idle();

            case (ph)
                0: begin
                    off = 16'h8000; wlen = 9'd0; dk = 16'd0; cf = 32'd0;
                end
                1: begin
                    off = 16'h7FFF; wlen = 9'd511; dk = 16'hFFFF; cf = 32'hFFFF_FFFF;
                end
                default: begin
                    case ($urandom_range(2))
                        0:       off = 16'($urandom);
                        1:       off = 16'($urandom_range(0, 4000)) - 16'd2000;
                        default: off = '0;
                    endcase
                    case ($urandom_range(5))
                        0:       wlen = 9'($urandom_range(1, 4));
                        1:       wlen = 9'($urandom_range(5, 64));
                        2:       wlen = WLEN_RST;
                        3:       wlen = 9'($urandom_range(65, 256));
                        4:       wlen = 9'($urandom_range(257, 511));
                        default: wlen = 9'd256;
                    endcase
                    case ($urandom_range(3))
                        0:       dk = 16'($urandom_range(60000, 65535));
                        1:       dk = 16'($urandom);
                        2:       dk = DECAY_RST;
                        default: dk = 16'($urandom_range(0, 1000));
                    endcase
                    case ($urandom_range(4))
                        0:       cf = $urandom_range(1, 2000);
                        1:       cf = $urandom_range(2000, 1 << 20);
                        2:       cf = $urandom;
                        3:       cf = COEFF_RST;
                        default: cf = '0;
                    endcase
                end
            endcase
            write_reg(CFG_DC_OFFSET, {16'b0, off});
            write_reg(CFG_WINDOW_LENGTH, {23'b0, wlen});
            write_reg(CFG_DECAY_FACTOR, {16'b0, dk});
            write_reg(CFG_PARABOLA_COEFF, cf);

            // sometimes carry the old record across the new window length
            keep_record = (ph == 2) || ($urandom_range(2) == 0);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
                rec_len = ($urandom_range(7) == 0) ? $urandom_range(200, 320)
                                                   : $urandom_range(1, 60);
                shape   = $urandom_range(3);
                burst   = $urandom_range(1, 12);
                for (int j = 0; j < rec_len && phase_items < RANDOM_ITEMS / NUM_PHASES; j++) begin
                    sor = ((j == 0) && !keep_record) || ($urandom_range(63) == 0);
                    smp = make_sample(shape, j < burst);
                    send_sample(smp, sor, 1'b0, '0);
                    phase_items++;
                    if ($urandom_range(199) == 0)
                        wait_idle();
                end
                keep_record = 1'b0;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_env_q.size() == 0)
            $display("envelope_smoother_decay_tb: clean");
        else
            $display("envelope_smoother_decay_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/esd_pkg.sv
sv/esd_div.sv
sv/esd_dp.sv
sv/esd_ctrl.sv
sv/envelope_smoother_decay.sv
sim/envelope_smoother_decay_tb.sv
